### rtl/urxfifo_pkg.sv
package urxfifo_pkg;

  localparam int unsigned ADDR_W_MAX = 12;
  localparam int unsigned FILL_W_MAX = 13;
  localparam int unsigned CNT_W      = 7;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_FLUSH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CMD_NOTE = 2'd0,
    CMD_PUSH = 2'd1,
    CMD_READ = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t               kind;
    logic [7:0]              wr_byte;
    logic [ADDR_W_MAX-1:0]   addr;
    logic [CNT_W-1:0]        count;
    logic                    dropped;
    logic [FILL_W_MAX-1:0]   fill;
  } cmd_t;

  typedef enum logic {
    BK_IDLE = 1'b0,
    BK_READ = 1'b1
  } back_state_t;

endpackage

### rtl/urxfifo_front.sv
module urxfifo_front import urxfifo_pkg::*; #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_op,
  input  logic [7:0]       in_rx_byte,
  input  logic [CNT_W-1:0] in_request_count,
  input  logic             q_full,
  output logic             q_push,
  output cmd_t             q_cmd
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);
  localparam int unsigned CW = (FW > CNT_W) ? FW : CNT_W;
  localparam int unsigned SW = ((AW > CNT_W) ? AW : CNT_W) + 1;

  logic [FW-1:0]    held_r, held_nxt;
  logic [AW-1:0]    rd_idx_r, rd_idx_nxt;
  logic [AW-1:0]    wr_idx_r, wr_idx_nxt;
  logic             full;
  logic [CNT_W-1:0] req_sat;
  logic [CNT_W-1:0] n;
  logic [SW-1:0]    rd_sum;
  logic [SW-1:0]    rd_wrap;
  logic [AW-1:0]    wr_inc;

  assign q_push = in_valid && !q_full;

  always_comb begin
    full    = (held_r == FW'(DEPTH));
    req_sat = (in_request_count > CNT_W'(MAX_READ)) ? CNT_W'(MAX_READ) : in_request_count;
    n       = (CW'(req_sat) > CW'(held_r)) ? CNT_W'(held_r) : req_sat;
    rd_sum  = SW'(rd_idx_r) + SW'(n);
    rd_wrap = (rd_sum >= SW'(DEPTH)) ? (rd_sum - SW'(DEPTH)) : rd_sum;
    wr_inc  = (wr_idx_r == AW'(DEPTH - 1)) ? '0 : (wr_idx_r + 1'b1);

    held_nxt   = held_r;
    rd_idx_nxt = rd_idx_r;
    wr_idx_nxt = wr_idx_r;

    q_cmd         = '0;
    q_cmd.kind    = CMD_NOTE;
    q_cmd.wr_byte = in_rx_byte;

    unique case (op_t'(in_op))
      OP_PUSH: begin
        if (full) begin
          q_cmd.dropped = 1'b1;
        end else begin
          q_cmd.kind = CMD_PUSH;
          q_cmd.addr = ADDR_W_MAX'(wr_idx_r);
          wr_idx_nxt = wr_inc;
          held_nxt   = held_r + 1'b1;
        end
      end
      OP_READ: begin
        if (n != '0) begin
          q_cmd.kind  = CMD_READ;
          q_cmd.addr  = ADDR_W_MAX'(rd_idx_r);
          q_cmd.count = n;
          rd_idx_nxt  = AW'(rd_wrap);
          held_nxt    = held_r - FW'(n);
        end
      end
      OP_FLUSH: begin
        held_nxt   = '0;
        rd_idx_nxt = '0;
        wr_idx_nxt = '0;
      end
      default: begin
      end
    endcase

    q_cmd.fill = FILL_W_MAX'(held_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r   <= '0;
      rd_idx_r <= '0;
      wr_idx_r <= '0;
    end else if (q_push) begin
      held_r   <= held_nxt;
      rd_idx_r <= rd_idx_nxt;
      wr_idx_r <= wr_idx_nxt;
    end
  end

endmodule

### rtl/urxfifo_queue.sv
module urxfifo_queue import urxfifo_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic valid,
  output logic full,
  output cmd_t head
);

  cmd_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r, cnt_nxt;

  assign valid = (cnt_r != 2'd0);
  assign full  = (cnt_r == 2'd2);
  assign head  = slot_r[rp_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
    end
  end

endmodule

### rtl/urxfifo_back.sv
module urxfifo_back import urxfifo_pkg::*; #(
  parameter int unsigned DEPTH = 256
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  cmd_t                         cmd,
  output logic                         cmd_pop,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_data_byte,
  output logic                         out_data_valid,
  output logic                         out_last,
  output logic [CNT_W-1:0]             out_delivered_total,
  output logic                         out_dropped,
  output logic [$clog2(DEPTH+1)-1:0]   out_fill_count
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FW = $clog2(DEPTH + 1);

  logic [7:0]       mem [DEPTH];

  back_state_t      state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic [CNT_W-1:0] tot_r, tot_nxt;
  logic [FW-1:0]    fill_r, fill_nxt;

  logic             s1_v_r, s1_v_nxt;
  logic             s1_last_r;
  logic [7:0]       rdata_r;

  logic             out_v_r, out_v_nxt;
  logic [7:0]       out_data_r;
  logic             out_dv_r;
  logic             out_last_r;
  logic [CNT_W-1:0] out_tot_r;
  logic             out_drop_r;
  logic [FW-1:0]    out_fill_r;

  logic             out_free;
  logic             s1_adv;
  logic             issue;
  logic             pop_single;
  logic             pop_read;
  logic             wr_en;
  logic [AW-1:0]    addr_inc;

  assign out_free = !out_v_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign addr_inc = (addr_r == AW'(DEPTH - 1)) ? '0 : (addr_r + 1'b1);
  assign cmd_pop  = pop_read || pop_single;
  assign wr_en    = pop_single && (cmd.kind == CMD_PUSH);

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    addr_nxt   = addr_r;
    tot_nxt    = tot_r;
    fill_nxt   = fill_r;
    issue      = 1'b0;
    pop_single = 1'b0;
    pop_read   = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid && !s1_v_r) begin
          if (cmd.kind == CMD_READ) begin
            pop_read  = 1'b1;
            state_nxt = BK_READ;
            cnt_nxt   = cmd.count;
            addr_nxt  = AW'(cmd.addr);
            tot_nxt   = cmd.count;
            fill_nxt  = FW'(cmd.fill);
          end else if (out_free) begin
            pop_single = 1'b1;
          end
        end
      end
      BK_READ: begin
        if (!s1_v_r || s1_adv) begin
          issue    = 1'b1;
          cnt_nxt  = cnt_r - 1'b1;
          addr_nxt = addr_inc;
          if (cnt_r == CNT_W'(1)) begin
            state_nxt = BK_IDLE;
          end
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    s1_v_nxt = s1_v_r;
    if (issue) begin
      s1_v_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r && out_stall;
    if (s1_adv || pop_single) begin
      out_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(cmd.addr)] <= cmd.wr_byte;
    end
    if (issue) begin
      rdata_r <= mem[addr_r];
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    addr_r <= addr_nxt;
    tot_r  <= tot_nxt;
    fill_r <= fill_nxt;
    if (issue) begin
      s1_last_r <= (cnt_r == CNT_W'(1));
    end
    if (s1_adv) begin
      out_data_r <= rdata_r;
      out_dv_r   <= 1'b1;
      out_last_r <= s1_last_r;
      out_tot_r  <= tot_r;
      out_drop_r <= 1'b0;
      out_fill_r <= fill_r;
    end else if (pop_single) begin
      out_data_r <= 8'd0;
      out_dv_r   <= 1'b0;
      out_last_r <= 1'b1;
      out_tot_r  <= '0;
      out_drop_r <= cmd.dropped;
      out_fill_r <= FW'(cmd.fill);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  assign out_valid           = out_v_r;
  assign out_data_byte       = out_data_r;
  assign out_data_valid      = out_dv_r;
  assign out_last            = out_last_r;
  assign out_delivered_total = out_tot_r;
  assign out_dropped         = out_drop_r;
  assign out_fill_count      = out_fill_r;

endmodule

### rtl/uart_rx_ring_fifo.sv
// A push, flush or empty read shows its single result via the queue slot and the output register;
// a read of N bytes goes via the queue slot, read state, read-data and output registers, and then
// shows one byte a cycle while out_stall is low. Pushes and flushes go one a cycle while in_stall
// is low; a read holds the single-port byte store and its registered read data until it is done.
// Reset (rst_n low, synchronous): store empties, both indices go to zero; stored bytes are kept.
module uart_rx_ring_fifo import urxfifo_pkg::*; #(
  parameter int unsigned DEPTH    = 256,
  parameter int unsigned MAX_READ = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic [7:0]                   in_rx_byte,
  input  logic [CNT_W-1:0]             in_request_count,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   out_data_byte,
  output logic                         out_data_valid,
  output logic                         out_last,
  output logic [CNT_W-1:0]             out_delivered_total,
  output logic                         out_dropped,
  output logic [$clog2(DEPTH+1)-1:0]   out_fill_count
);

  logic q_push;
  logic q_pop;
  logic q_valid;
  logic q_full;
  cmd_t q_in_cmd;
  cmd_t q_head;

  assign in_stall = q_full;

  urxfifo_front #(
    .DEPTH    (DEPTH),
    .MAX_READ (MAX_READ)
  ) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_op            (in_op),
    .in_rx_byte       (in_rx_byte),
    .in_request_count (in_request_count),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_cmd            (q_in_cmd)
  );

  urxfifo_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_in_cmd),
    .pop      (q_pop),
    .valid    (q_valid),
    .full     (q_full),
    .head     (q_head)
  );

  urxfifo_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd_valid           (q_valid),
    .cmd                 (q_head),
    .cmd_pop             (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_data_byte       (out_data_byte),
    .out_data_valid      (out_data_valid),
    .out_last            (out_last),
    .out_delivered_total (out_delivered_total),
    .out_dropped         (out_dropped),
    .out_fill_count      (out_fill_count)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_byte_has_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data_valid) |-> (out_delivered_total != '0))
    else $error("delivered byte with zero total");

  a_note_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data_valid) |-> (out_last && (out_delivered_total == '0)))
    else $error("single result not marked last");

  a_drop_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dropped) |-> (out_fill_count == $bits(out_fill_count)'(DEPTH)))
    else $error("drop reported below full");
`endif

endmodule
